// File: rtl/ptpm_pkg.sv
package ptpm_pkg;

   localparam int PORT_COUNT = 3;
   localparam int PORT_W = 2;
   localparam int PORT_IDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
   localparam int DATA_W = 32;
   localparam int PERIOD_W = 16;
   localparam int DIV_STEP_W = $clog2(DATA_W);
   localparam logic [DATA_W-1:0] MS_PER_SEC = 32'd1000;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

   typedef enum logic [1:0] {
      EVT_RX   = 2'd0,
      EVT_TX   = 2'd1,
      EVT_LAT  = 2'd2,
      EVT_TICK = 2'd3
   } evt_type;

   typedef enum logic [1:0] {
      OPD_RX,
      OPD_TX,
      OPD_LAT
   } opd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCALE,
      ST_START,
      ST_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                  record;
      logic                  tick;
      logic                  report;
      logic [PORT_IDX_W-1:0] idx;
      opd_type               opd;
      logic                  op_load;
      logic                  op_scale;
      logic                  div_start;
      logic                  capture;
      logic                  out_load;
   } ptpm_cmd_type;

   typedef struct packed {
      logic tick_due;
      logic div_done;
      logic out_free;
   } ptpm_status_type;

endpackage

// File: rtl/port_traffic_perf_monitor.sv
// An rx, tx or latency word is recorded when it is taken and needs no result.
// A tick that is due starts a report: per port two rate divisions and one mean
// division run one after another on a single shift-subtract divider, and each
// port's report word waits while the output holds a word that rsp_ready has not taken.
// Throughput: one word per cycle outside reports; no word is taken during one.
// Reset (synchronous) clears all totals and the report time; the period reads 1000.
module port_traffic_perf_monitor (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic [ptpm_pkg::PORT_W-1:0]   req_port,
   input  logic [ptpm_pkg::DATA_W-1:0]   req_amount,
   input  logic [ptpm_pkg::DATA_W-1:0]   req_now_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ptpm_pkg::PORT_W-1:0]   rsp_report_port,
   output logic [ptpm_pkg::DATA_W-1:0]   rsp_rx_rate,
   output logic [ptpm_pkg::DATA_W-1:0]   rsp_tx_rate,
   output logic [ptpm_pkg::DATA_W-1:0]   rsp_latency_avg,
   output logic [ptpm_pkg::DATA_W-1:0]   rsp_latency_peak,
   output logic [ptpm_pkg::DATA_W-1:0]   rsp_sample_count,
   output logic                          rsp_last_line,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ptpm_pkg::PERIOD_W-1:0] csr_report_period_ms
);

   ptpm_pkg::ptpm_cmd_type    cmd;
   ptpm_pkg::ptpm_status_type status;

   assign csr_ready = 1'b1;

   ptpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ptpm_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_type             (req_type),
      .req_port             (req_port),
      .req_amount           (req_amount),
      .req_now_ms           (req_now_ms),
      .csr_valid            (csr_valid),
      .csr_report_period_ms (csr_report_period_ms),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_report_port      (rsp_report_port),
      .rsp_rx_rate          (rsp_rx_rate),
      .rsp_tx_rate          (rsp_tx_rate),
      .rsp_latency_avg      (rsp_latency_avg),
      .rsp_latency_peak     (rsp_latency_peak),
      .rsp_sample_count     (rsp_sample_count),
      .rsp_last_line        (rsp_last_line)
   );

   // A due tick must close the input side while the report runs.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.tick && status.tick_due) |=> !req_ready)
      else $error("input still open after a report started");

   // A report word is loaded only when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("report word loaded over a pending word");

   // Only ports that exist are ever reported.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_report_port) < ptpm_pkg::PORT_COUNT))
      else $error("report names a port out of range");

   // The divider is never restarted while its result is being captured.
   assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> !cmd.div_start)
      else $error("divider restarted during capture");

endmodule

// File: rtl/ptpm_div.sv
module ptpm_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ptpm_pkg::DATA_W-1:0]  dividend,
   input  logic [ptpm_pkg::DATA_W-1:0]  divisor,
   output logic [ptpm_pkg::DATA_W-1:0]  quotient,
   output logic                         done
);

   logic                              busy_ff;
   logic                              done_ff;
   logic [ptpm_pkg::DIV_STEP_W-1:0]   cnt_ff;
   logic [ptpm_pkg::DATA_W-1:0]       quo_ff;
   logic [ptpm_pkg::DATA_W-1:0]       rem_ff;
   logic [ptpm_pkg::DATA_W-1:0]       dvs_ff;
   logic [ptpm_pkg::DATA_W:0]         rem_sh;
   logic [ptpm_pkg::DATA_W:0]         diff;
   logic                              ge;

   // Restoring division, one quotient bit per cycle, most significant first.
   assign rem_sh = {rem_ff, quo_ff[ptpm_pkg::DATA_W-1]};
   assign diff = rem_sh - {1'b0, dvs_ff};
   assign ge = ~diff[ptpm_pkg::DATA_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == ptpm_pkg::DIV_STEP_W'(ptpm_pkg::DATA_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[ptpm_pkg::DATA_W-2:0], ge};
         rem_ff <= ge ? diff[ptpm_pkg::DATA_W-1:0] : rem_sh[ptpm_pkg::DATA_W-1:0];
      end
   end

   assign quotient = quo_ff;
   assign done = done_ff;

endmodule

// File: rtl/ptpm_ctrl.sv
module ptpm_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [1:0]                 req_type,
   output logic                       req_ready,
   input  ptpm_pkg::ptpm_status_type  status,
   output ptpm_pkg::ptpm_cmd_type     cmd
);

   ptpm_pkg::state_type                 state_ff, state_in;
   ptpm_pkg::opd_type                   opd_ff, opd_in;
   logic [ptpm_pkg::PORT_IDX_W-1:0]     idx_ff, idx_in;
   logic                                accept;
   logic                                is_tick;

   assign accept = req_valid && (state_ff == ptpm_pkg::ST_IDLE);
   assign is_tick = (req_type == ptpm_pkg::EVT_TICK);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptpm_pkg::ST_IDLE;
         opd_ff <= ptpm_pkg::OPD_RX;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         opd_ff <= opd_in;
         idx_ff <= idx_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      opd_in = opd_ff;
      idx_in = idx_ff;
      unique case (state_ff)
         ptpm_pkg::ST_IDLE: begin
            if (accept && is_tick && status.tick_due) begin
               state_in = ptpm_pkg::ST_LOAD;
               opd_in = ptpm_pkg::OPD_RX;
               idx_in = '0;
            end
         end
         ptpm_pkg::ST_LOAD: begin
            state_in = (opd_ff == ptpm_pkg::OPD_LAT) ? ptpm_pkg::ST_START
                                                     : ptpm_pkg::ST_SCALE;
         end
         ptpm_pkg::ST_SCALE: state_in = ptpm_pkg::ST_START;
         ptpm_pkg::ST_START: state_in = ptpm_pkg::ST_WAIT;
         ptpm_pkg::ST_WAIT: begin
            if (status.div_done) begin
               unique case (opd_ff)
                  ptpm_pkg::OPD_RX: begin
                     opd_in = ptpm_pkg::OPD_TX;
                     state_in = ptpm_pkg::ST_LOAD;
                  end
                  ptpm_pkg::OPD_TX: begin
                     opd_in = ptpm_pkg::OPD_LAT;
                     state_in = ptpm_pkg::ST_LOAD;
                  end
                  default: state_in = ptpm_pkg::ST_EMIT;
               endcase
            end
         end
         ptpm_pkg::ST_EMIT: begin
            if (status.out_free) begin
               if (idx_ff == ptpm_pkg::PORT_IDX_W'(ptpm_pkg::PORT_COUNT - 1)) begin
                  state_in = ptpm_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  opd_in = ptpm_pkg::OPD_RX;
                  state_in = ptpm_pkg::ST_LOAD;
               end
            end
         end
         default: state_in = ptpm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd = '0;
      cmd.idx = idx_ff;
      cmd.opd = opd_ff;
      unique case (state_ff)
         ptpm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.record = accept && !is_tick;
            cmd.tick = accept && is_tick;
         end
         ptpm_pkg::ST_LOAD: begin
            cmd.report = 1'b1;
            cmd.op_load = 1'b1;
         end
         ptpm_pkg::ST_SCALE: begin
            cmd.report = 1'b1;
            cmd.op_scale = 1'b1;
         end
         ptpm_pkg::ST_START: begin
            cmd.report = 1'b1;
            cmd.div_start = 1'b1;
         end
         ptpm_pkg::ST_WAIT: begin
            cmd.report = 1'b1;
            cmd.capture = status.div_done;
         end
         ptpm_pkg::ST_EMIT: begin
            cmd.report = 1'b1;
            cmd.out_load = status.out_free;
         end
         default: begin
            cmd.report = 1'b0;
         end
      endcase
   end

endmodule

// File: rtl/ptpm_dp.sv
module ptpm_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  ptpm_pkg::ptpm_cmd_type        cmd,
   output ptpm_pkg::ptpm_status_type     status,
   input  logic [1:0]                    req_type,
   input  logic [ptpm_pkg::PORT_W-1:0]   req_port,
   input  logic [ptpm_pkg::DATA_W-1:0]   req_amount,
   input  logic [ptpm_pkg::DATA_W-1:0]   req_now_ms,
   input  logic                          csr_valid,
   input  logic [ptpm_pkg::PERIOD_W-1:0] csr_report_period_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ptpm_pkg::PORT_W-1:0]   rsp_report_port,
   output logic [ptpm_pkg::DATA_W-1:0]   rsp_rx_rate,
   output logic [ptpm_pkg::DATA_W-1:0]   rsp_tx_rate,
   output logic [ptpm_pkg::DATA_W-1:0]   rsp_latency_avg,
   output logic [ptpm_pkg::DATA_W-1:0]   rsp_latency_peak,
   output logic [ptpm_pkg::DATA_W-1:0]   rsp_sample_count,
   output logic                          rsp_last_line
);

   localparam int DW = ptpm_pkg::DATA_W;
   localparam int PC = ptpm_pkg::PORT_COUNT;

   logic [DW-1:0] rx_total_ff [PC];
   logic [DW-1:0] tx_total_ff [PC];
   logic [DW-1:0] rx_at_ff [PC];
   logic [DW-1:0] tx_at_ff [PC];
   logic [DW-1:0] lat_total_ff [PC];
   logic [DW-1:0] lat_count_ff [PC];
   logic [DW-1:0] lat_max_ff [PC];

   logic [DW-1:0]                     last_report_ff;
   logic [ptpm_pkg::PERIOD_W-1:0]     period_ff;
   logic [DW-1:0]                     elapsed_ff;
   logic [DW-1:0]                     num_ff;
   logic [DW-1:0]                     rx_q_ff, tx_q_ff, avg_q_ff;
   logic                              rsp_valid_ff;
   logic [ptpm_pkg::PORT_W-1:0]       report_port_ff;
   logic [DW-1:0]                     rx_rate_ff, tx_rate_ff, avg_ff, peak_ff, count_ff;
   logic                              last_line_ff;

   logic [ptpm_pkg::PORT_IDX_W-1:0]   rd_idx;
   logic                              port_ok;
   logic [DW-1:0]                     elapsed;
   logic [DW-1:0]                     period_eff;
   logic                              first_tick;
   logic [DW-1:0]                     operand;
   logic [DW-1:0]                     divisor;
   logic [DW-1:0]                     quotient;
   logic                              div_done;

   // Outside a report the stores are read at the event's port, during one at the
   // port being reported.
   assign rd_idx = cmd.report ? cmd.idx : ptpm_pkg::PORT_IDX_W'(req_port);
   assign port_ok = (int'(req_port) < PC);

   assign period_eff = (period_ff == '0) ? DW'(1) : DW'(period_ff);
   assign elapsed = req_now_ms - last_report_ff;
   assign first_tick = (last_report_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= ptpm_pkg::PERIOD_RESET;
      end else if (csr_valid) begin
         period_ff <= csr_report_period_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_report_ff <= '0;
      end else if (cmd.tick && (first_tick || elapsed >= period_eff)) begin
         last_report_ff <= req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tick) begin
         elapsed_ff <= elapsed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PC; p++) begin
            rx_total_ff[p] <= '0;
            tx_total_ff[p] <= '0;
            rx_at_ff[p] <= '0;
            tx_at_ff[p] <= '0;
            lat_total_ff[p] <= '0;
            lat_count_ff[p] <= '0;
            lat_max_ff[p] <= '0;
         end
      end else begin
         for (int p = 0; p < PC; p++) begin
            if (cmd.record && port_ok && (rd_idx == ptpm_pkg::PORT_IDX_W'(p))) begin
               case (ptpm_pkg::evt_type'(req_type))
                  ptpm_pkg::EVT_RX: rx_total_ff[p] <= rx_total_ff[p] + req_amount;
                  ptpm_pkg::EVT_TX: tx_total_ff[p] <= tx_total_ff[p] + req_amount;
                  ptpm_pkg::EVT_LAT: begin
                     lat_total_ff[p] <= lat_total_ff[p] + req_amount;
                     lat_count_ff[p] <= lat_count_ff[p] + 1'b1;
                     if (req_amount > lat_max_ff[p]) begin
                        lat_max_ff[p] <= req_amount;
                     end
                  end
                  default: ;
               endcase
            end
            if (cmd.out_load && (cmd.idx == ptpm_pkg::PORT_IDX_W'(p))) begin
               rx_at_ff[p] <= rx_total_ff[p];
               tx_at_ff[p] <= tx_total_ff[p];
               lat_total_ff[p] <= '0;
               lat_count_ff[p] <= '0;
               lat_max_ff[p] <= '0;
            end
         end
      end
   end

   always_comb begin
      case (cmd.opd)
         ptpm_pkg::OPD_RX: operand = rx_total_ff[rd_idx] - rx_at_ff[rd_idx];
         ptpm_pkg::OPD_TX: operand = tx_total_ff[rd_idx] - tx_at_ff[rd_idx];
         default:          operand = lat_total_ff[rd_idx];
      endcase
   end

   assign divisor = (cmd.opd == ptpm_pkg::OPD_LAT) ? lat_count_ff[rd_idx] : elapsed_ff;

   always_ff @(posedge clock) begin
      if (cmd.op_load) begin
         num_ff <= operand;
      end else if (cmd.op_scale) begin
         num_ff <= DW'(num_ff * ptpm_pkg::MS_PER_SEC);
      end
   end

   ptpm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (num_ff),
      .divisor  (divisor),
      .quotient (quotient),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         case (cmd.opd)
            ptpm_pkg::OPD_RX: rx_q_ff <= quotient;
            ptpm_pkg::OPD_TX: tx_q_ff <= quotient;
            default: avg_q_ff <= (lat_count_ff[rd_idx] == '0) ? '0 : quotient;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         report_port_ff <= ptpm_pkg::PORT_W'(cmd.idx);
         rx_rate_ff <= rx_q_ff;
         tx_rate_ff <= tx_q_ff;
         avg_ff <= avg_q_ff;
         peak_ff <= lat_max_ff[rd_idx];
         count_ff <= lat_count_ff[rd_idx];
         last_line_ff <= (cmd.idx == ptpm_pkg::PORT_IDX_W'(PC - 1));
      end
   end

   assign status.tick_due = !first_tick && (elapsed >= period_eff);
   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_report_port = report_port_ff;
   assign rsp_rx_rate = rx_rate_ff;
   assign rsp_tx_rate = tx_rate_ff;
   assign rsp_latency_avg = avg_ff;
   assign rsp_latency_peak = peak_ff;
   assign rsp_sample_count = count_ff;
   assign rsp_last_line = last_line_ff;

endmodule
